// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define OCLC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent (the consequent may carry a ## delay).
`define OCLC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);

`endif

// ----- sv/oclc_pkg.sv -----
// Shared constants and types for the octree level and cell locator.
`default_nettype none

package oclc_pkg;

    localparam int MAX_LEVELS = 8;
    localparam int FRAC_BITS  = 8;
    localparam int COORD_BITS = 24;

    localparam int HALF_BITS  = COORD_BITS - 1;        // half-size width
    localparam int DIFF_BITS  = COORD_BITS + 2;        // box corner after origin offset
    localparam int EXT_BITS   = COORD_BITS;            // twice the largest half-size
    localparam int LOG_W      = $clog2(EXT_BITS + 1);  // ceil log2 of extent
    localparam int LVL_W      = 3;
    localparam int IDX_W      = 21;
    localparam int CELL_W     = MAX_LEVELS - 1;        // per-axis cell coordinate
    localparam int SHIFT_W    = 5;                     // cell shift, up to 15 + FRAC_BITS + 1
    localparam int LRS_W      = 4;
    localparam int LC_W       = 4;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int LATENCY    = 5;

    localparam logic [LRS_W-1:0] LRS_RESET = 4'd10;
    localparam logic [LC_W-1:0]  LC_RESET  = 4'd8;

    typedef enum logic [2:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_ORIGIN_Z  = 3'd2,
        REG_LOG2_SIZE = 3'd3,
        REG_LEVEL_CNT = 3'd4,
        REG_UNBOUNDED = 3'd5
    } reg_idx_t;

endpackage

`default_nettype wire

// ----- sv/octree_level_cell_locator_unit.sv -----
// Octree level and cell locator: five-stage pipeline with an APB register port.
`default_nettype none

// Usage
//   Input: drive start high with a box (center_x/y/z signed Q15.8, half_x/y/z
//   unsigned Q15.8). The item is taken at the clock edge where start is high
//   and busy is low. busy is high only in the first cycle after reset, so the
//   block takes one item every cycle from then on.
//   Output: done pulses for one cycle with level and cell_index, once the
//   item has passed the register stages, in input order. The receiver cannot
//   stall the block; it must take each result in its done cycle.
//   Throughput: 1 item per cycle. Register stages, in order: origin offset
//   and extent, extent log2, level pick, corner cell shifts, index pack.
//   Registers (APB, byte address 4*i): origin_x/y/z, log2_region_size,
//   level_count, unbounded_mode. Write them only while no item is in flight.
//   pready is always high; reads return the register value.
//   Reset: rst_n (async, active low) clears the pipeline valid bits and loads
//   the register reset values (origin 0, region 2^10, 8 levels, bounded).

module octree_level_cell_locator_unit (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    // item input
    input  wire logic                                      start,
    output logic                                           busy,
    input  wire logic signed [oclc_pkg::COORD_BITS-1:0]    center_x,
    input  wire logic signed [oclc_pkg::COORD_BITS-1:0]    center_y,
    input  wire logic signed [oclc_pkg::COORD_BITS-1:0]    center_z,
    input  wire logic        [oclc_pkg::HALF_BITS-1:0]     half_x,
    input  wire logic        [oclc_pkg::HALF_BITS-1:0]     half_y,
    input  wire logic        [oclc_pkg::HALF_BITS-1:0]     half_z,
    // result output
    output logic                                           done,
    output logic             [oclc_pkg::LVL_W-1:0]         level,
    output logic             [oclc_pkg::IDX_W-1:0]         cell_index,
    // configuration port
    input  wire logic                                      psel,
    input  wire logic                                      penable,
    input  wire logic                                      pwrite,
    input  wire logic        [oclc_pkg::PADDR_W-1:0]       paddr,
    input  wire logic        [oclc_pkg::PDATA_W-1:0]       pwdata,
    output logic             [oclc_pkg::PDATA_W-1:0]       prdata,
    output logic                                           pready
);

    localparam int CW = oclc_pkg::COORD_BITS;
    localparam int DW = oclc_pkg::DIFF_BITS;
    localparam int HW = oclc_pkg::HALF_BITS;
    localparam int EW = oclc_pkg::EXT_BITS;
    localparam int GW = oclc_pkg::LOG_W;
    localparam int VW = oclc_pkg::LVL_W;
    localparam int XW = oclc_pkg::IDX_W;
    localparam int NW = oclc_pkg::CELL_W;
    localparam int SW = oclc_pkg::SHIFT_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [CW-1:0]              origin_reg [3];
    logic [oclc_pkg::LRS_W-1:0]        lrs_reg;
    logic [oclc_pkg::LC_W-1:0]         lc_reg;
    logic                              unbounded_reg;
    logic                              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            lrs_reg       <= oclc_pkg::LRS_RESET;
            lc_reg        <= oclc_pkg::LC_RESET;
            unbounded_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (oclc_pkg::reg_idx_t'(paddr[4:2]))
                oclc_pkg::REG_ORIGIN_X:  origin_reg[0] <= pwdata[CW-1:0];
                oclc_pkg::REG_ORIGIN_Y:  origin_reg[1] <= pwdata[CW-1:0];
                oclc_pkg::REG_ORIGIN_Z:  origin_reg[2] <= pwdata[CW-1:0];
                oclc_pkg::REG_LOG2_SIZE: lrs_reg       <= pwdata[oclc_pkg::LRS_W-1:0];
                oclc_pkg::REG_LEVEL_CNT: lc_reg        <= pwdata[oclc_pkg::LC_W-1:0];
                oclc_pkg::REG_UNBOUNDED: unbounded_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (oclc_pkg::reg_idx_t'(paddr[4:2]))
            oclc_pkg::REG_ORIGIN_X:  prdata = oclc_pkg::PDATA_W'(origin_reg[0]);
            oclc_pkg::REG_ORIGIN_Y:  prdata = oclc_pkg::PDATA_W'(origin_reg[1]);
            oclc_pkg::REG_ORIGIN_Z:  prdata = oclc_pkg::PDATA_W'(origin_reg[2]);
            oclc_pkg::REG_LOG2_SIZE: prdata = oclc_pkg::PDATA_W'(lrs_reg);
            oclc_pkg::REG_LEVEL_CNT: prdata = oclc_pkg::PDATA_W'(lc_reg);
            oclc_pkg::REG_UNBOUNDED: prdata = oclc_pkg::PDATA_W'(unbounded_reg);
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input acceptance; busy only covers the first cycle out of reset
    // ------------------------------------------------------------------
    logic busy_reg;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= 1'b0;
    end

    assign busy   = busy_reg;
    assign accept = start & ~busy_reg;

    // Valid bits, one per stage
    logic v1_reg, v2_reg, v3_reg, v4_reg, done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: subtract origin, form min / max-minus-one corners, extent
    // ------------------------------------------------------------------
    logic signed [CW-1:0] center [3];
    logic        [HW-1:0] half   [3];
    logic signed [DW-1:0] c_off  [3];
    logic signed [DW-1:0] h_ext  [3];
    logic signed [DW-1:0] lo_next [3];
    logic signed [DW-1:0] hi_next [3];
    logic        [EW-1:0] e_axis [3];
    logic        [EW-1:0] ext_max;
    logic        [EW-1:0] ext_next;

    assign center[0] = center_x;
    assign center[1] = center_y;
    assign center[2] = center_z;
    assign half[0]   = half_x;
    assign half[1]   = half_y;
    assign half[2]   = half_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_off[i]   = DW'(center[i]) - DW'(origin_reg[i]);
            h_ext[i]   = $signed({{(DW-HW){1'b0}}, half[i]});
            lo_next[i] = c_off[i] - h_ext[i];
            hi_next[i] = c_off[i] + h_ext[i] - DW'(1);
            e_axis[i]  = {half[i], 1'b0};
        end
        ext_max = (e_axis[0] > e_axis[1]) ? e_axis[0] : e_axis[1];
        if (e_axis[2] > ext_max)
            ext_max = e_axis[2];
        // zero-size box counts as one LSB
        ext_next = (ext_max == '0) ? EW'(1) : ext_max;
    end

    logic signed [DW-1:0] lo1_reg [3];
    logic signed [DW-1:0] hi1_reg [3];
    logic        [EW-1:0] ext1_reg;

    always_ff @(posedge clk)
    begin
        lo1_reg  <= lo_next;
        hi1_reg  <= hi_next;
        ext1_reg <= ext_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: ceil(log2(extent)) as the bit length of extent - 1
    // ------------------------------------------------------------------
    logic [EW-1:0] ext_m1;
    logic [GW-1:0] clog_next;

    always_comb
    begin
        ext_m1    = ext1_reg - EW'(1);
        clog_next = '0;
        for (int b = 0; b < EW; b++)
        begin
            if (ext_m1[b])
                clog_next = GW'(b + 1);
        end
    end

    logic signed [DW-1:0] lo2_reg [3];
    logic signed [DW-1:0] hi2_reg [3];
    logic        [GW-1:0] clog2_reg;

    always_ff @(posedge clk)
    begin
        lo2_reg   <= lo1_reg;
        hi2_reg   <= hi1_reg;
        clog2_reg <= clog_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: level pick, clamped to level count and region size
    // ------------------------------------------------------------------
    localparam int RW = 7;

    logic signed [RW-1:0]             raw_lvl;
    logic [oclc_pkg::LC_W-1:0]        lc_eff;
    logic [oclc_pkg::LC_W-1:0]        lc_top;
    logic [RW-1:0]                    lvl_wide;
    logic [VW-1:0]                    lvl_next;

    always_comb
    begin
        raw_lvl = $signed({{(RW-oclc_pkg::LRS_W){1'b0}}, lrs_reg})
                + RW'(oclc_pkg::FRAC_BITS)
                - $signed({{(RW-GW){1'b0}}, clog2_reg});
        if (lc_reg == '0)
            lc_eff = oclc_pkg::LC_W'(1);
        else if (lc_reg > oclc_pkg::LC_W'(oclc_pkg::MAX_LEVELS))
            lc_eff = oclc_pkg::LC_W'(oclc_pkg::MAX_LEVELS);
        else
            lc_eff = lc_reg;
        lc_top   = lc_eff - oclc_pkg::LC_W'(1);
        lvl_wide = raw_lvl[RW-1] ? '0 : raw_lvl;
        if (lvl_wide > RW'(lc_top))
            lvl_wide = RW'(lc_top);
        if (lvl_wide > RW'(lrs_reg))
            lvl_wide = RW'(lrs_reg);
        lvl_next = lvl_wide[VW-1:0];
    end

    logic signed [DW-1:0] lo3_reg [3];
    logic signed [DW-1:0] hi3_reg [3];
    logic        [VW-1:0] lvl3_reg;

    always_ff @(posedge clk)
    begin
        lo3_reg  <= lo2_reg;
        hi3_reg  <= hi2_reg;
        lvl3_reg <= lvl_next;
    end

    // ------------------------------------------------------------------
    // Stage 4: corner cells at the picked level and min cell one level up
    // ------------------------------------------------------------------
    function automatic logic [NW-1:0] cell_clamp(input logic signed [DW-1:0] v,
                                                 input logic [NW-1:0] top);
        logic signed [DW-1:0] top_s;
        top_s = $signed({{(DW-NW){1'b0}}, top});
        if (v < 0)
            return '0;
        else if (v > top_s)
            return top;
        else
            return v[NW-1:0];
    endfunction

    logic [SW-1:0]        sh_fine;
    logic [SW-1:0]        sh_coarse;
    logic [NW-1:0]        top_fine;
    logic [NW-1:0]        top_coarse;
    logic signed [DW-1:0] lo_sh  [3];
    logic signed [DW-1:0] lo_sh1 [3];
    logic signed [DW-1:0] hi_sh  [3];
    logic signed [DW-1:0] hi_cl  [3];
    logic [NW-1:0]        cmin_fine_next   [3];
    logic [NW-1:0]        cmin_coarse_next [3];
    logic                 differ_next;

    always_comb
    begin
        sh_fine     = SW'(lrs_reg) - SW'(lvl3_reg) + SW'(oclc_pkg::FRAC_BITS);
        sh_coarse   = sh_fine + SW'(1);
        top_fine    = NW'((8'd1 << lvl3_reg) - 8'd1);
        top_coarse  = top_fine >> 1;
        differ_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            lo_sh[i]  = lo3_reg[i] >>> sh_fine;
            lo_sh1[i] = lo3_reg[i] >>> sh_coarse;
            hi_sh[i]  = hi3_reg[i] >>> sh_fine;
            // max corner is only clamped from above
            hi_cl[i]  = (hi_sh[i] > $signed({{(DW-NW){1'b0}}, top_fine}))
                      ? $signed({{(DW-NW){1'b0}}, top_fine}) : hi_sh[i];
            cmin_fine_next[i]   = cell_clamp(lo_sh[i], top_fine);
            cmin_coarse_next[i] = cell_clamp(lo_sh1[i], top_coarse);
            if ($signed({{(DW-NW){1'b0}}, cmin_fine_next[i]}) != hi_cl[i])
                differ_next = 1'b1;
        end
    end

    logic [NW-1:0] cmin_fine_reg   [3];
    logic [NW-1:0] cmin_coarse_reg [3];
    logic          differ_reg;
    logic [VW-1:0] lvl4_reg;

    always_ff @(posedge clk)
    begin
        cmin_fine_reg   <= cmin_fine_next;
        cmin_coarse_reg <= cmin_coarse_next;
        differ_reg      <= differ_next;
        lvl4_reg        <= lvl3_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: step coarser on a straddle, 0 if unbounded, pack x + y*n + z*n*n
    // ------------------------------------------------------------------
    logic          coarser;
    logic [VW-1:0] lvl_final;
    logic [NW-1:0] cell_sel [3];
    logic [XW-1:0] index_next;
    logic [VW:0]   sh_z;

    always_comb
    begin
        coarser   = differ_reg && (lvl4_reg != '0);
        lvl_final = coarser ? (lvl4_reg - VW'(1)) : lvl4_reg;
        for (int i = 0; i < 3; i++)
            cell_sel[i] = coarser ? cmin_coarse_reg[i] : cmin_fine_reg[i];
        sh_z       = {lvl_final, 1'b0};
        index_next = XW'(cell_sel[0])
                   + (XW'(cell_sel[1]) << lvl_final)
                   + (XW'(cell_sel[2]) << sh_z);
    end

    logic [VW-1:0] level_reg;
    logic [XW-1:0] cell_index_reg;

    always_ff @(posedge clk)
    begin
        if (unbounded_reg)
        begin
            level_reg      <= '0;
            cell_index_reg <= '0;
        end
        else
        begin
            level_reg      <= lvl_final;
            cell_index_reg <= index_next;
        end
    end

    assign done       = done_reg;
    assign level      = level_reg;
    assign cell_index = cell_index_reg;

endmodule

`default_nettype wire

// ----- sv/oclc_checker.sv -----
// Port-level checker for the octree level and cell locator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module oclc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic [oclc_pkg::LVL_W-1:0]    level,
    input wire logic [oclc_pkg::IDX_W-1:0]    cell_index,
    input wire logic                          pready
);

    `OCLC_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
    `OCLC_ASSERT_IMPLIES(a_item_result, start && !busy, ##5 done, "result missing after item")
    `OCLC_ASSERT_IMPLIES(a_no_phantom, !(start && !busy), ##5 !done, "result without item")
    `OCLC_ASSERT_IMPLIES(a_index_range, done, ((cell_index >> (3 * level)) == '0), "index beyond level")

endmodule

bind octree_level_cell_locator_unit oclc_checker u_oclc_checker (.*);

`default_nettype wire
